### rtl/vap_pkg.sv
// Shared types and constants for the vehicle anomaly persistence block.
// Holds the transaction payload structs, register map and counter-row layout.
// No dependencies.
`default_nettype none

package vap_pkg;

  // Counter row layout: one 8-bit persistence counter per monitored condition
  localparam int NUM_CHANNELS = 10;
  localparam int CNT_W        = 8;
  localparam int ROW_W        = NUM_CHANNELS * CNT_W;

  // Field widths fixed by the interface
  localparam int VIDX_W   = 8;
  localparam int SAMPLE_W = 16;

  // Parameter defaults
  localparam int DEF_NUM_VEHICLES = 256;
  localparam int DEF_BRAKE_HOLD   = 4;
  localparam int DEF_DOOR_HOLD    = 4;
  localparam int DEF_STEER_HOLD   = 4;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Flag bit positions
  localparam int CH_OIL   = 0;
  localparam int CH_TRL   = 1;
  localparam int CH_TRR   = 2;
  localparam int CH_TFL   = 3;
  localparam int CH_TFR   = 4;
  localparam int CH_VOLT  = 5;
  localparam int CH_FUEL  = 6;
  localparam int CH_BRAKE = 7;
  localparam int CH_DOOR  = 8;
  localparam int CH_STEER = 9;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_OIL_MIN,
    REG_PRESSURE_MIN,
    REG_VOLTAGE_MIN,
    REG_FUEL_MIN,
    REG_OIL_HOLD,
    REG_PRESSURE_HOLD,
    REG_VOLTAGE_HOLD,
    REG_FUEL_HOLD
  } cfg_reg_t;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic [VIDX_W-1:0]   vehicle_index;
    logic [SAMPLE_W-1:0] oil_level;
    logic [SAMPLE_W-1:0] tire_rear_left;
    logic [SAMPLE_W-1:0] tire_rear_right;
    logic [SAMPLE_W-1:0] tire_front_left;
    logic [SAMPLE_W-1:0] tire_front_right;
    logic [SAMPLE_W-1:0] battery_voltage;
    logic [SAMPLE_W-1:0] fuel_level;
    logic                hard_braking;
    logic                door_locked;
    logic                hard_steering;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]       result_vehicle;
    logic [NUM_CHANNELS-1:0] anomaly_flags;
    logic                    any_anomaly;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/vehicle_anomaly_persistence.sv
// Top level of the vehicle anomaly persistence block: config registers,
// counter-row memory with read-modify-write pipeline and output register.
// Depends on vap_pkg.
//
// One telemetry sample per vehicle enters per transaction; the block keeps a
// row of ten saturating 8-bit persistence counters per vehicle in a single
// synchronous memory (one row per vehicle, one read and one write port) and
// returns one flag word per sample, bit k set when counter k sits at its hold
// limit. Throughput is one sample per clock while the result channel is not
// stalled: the row is read into a register at accept, updated in the update
// stage and written back as it advances; a back-to-back sample for the same
// vehicle takes the just-written row from a forwarding register. out_valid
// rises as the update stage hands its result to the output register. After
// reset the block sweeps the memory to zero, one row per cycle over all
// min(NUM_VEHICLES, 256) rows with in_ready low; config writes are taken throughout.
// Thresholds and holds must only be written while no sample is in flight.
`default_nettype none

module vehicle_anomaly_persistence #(
  parameter int NUM_VEHICLES = vap_pkg::DEF_NUM_VEHICLES,
  parameter int BRAKE_HOLD   = vap_pkg::DEF_BRAKE_HOLD,
  parameter int DOOR_HOLD    = vap_pkg::DEF_DOOR_HOLD,
  parameter int STEER_HOLD   = vap_pkg::DEF_STEER_HOLD
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // sample channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire vap_pkg::in_item_t               in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output vap_pkg::out_item_t                   out_data,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [vap_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [vap_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [vap_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  // Only indices reachable through the 8-bit vehicle field need a row
  localparam int ROWS = (NUM_VEHICLES < 256) ? NUM_VEHICLES : 256;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NC   = vap_pkg::NUM_CHANNELS;
  localparam int CW   = vap_pkg::CNT_W;
  localparam int SW   = vap_pkg::SAMPLE_W;
  localparam int DW   = vap_pkg::APB_DATA_W;

  // Counter update: returns {at_limit, new_count}
  function automatic logic [CW:0] step_cnt(input logic [CW-1:0] cnt,
                                           input logic          viol,
                                           input logic [CW-1:0] lim);
    logic [CW:0] nxt;
    logic [CW:0] lim_x;
    lim_x = {1'b0, lim};
    nxt   = {1'b0, cnt} + {{CW{1'b0}}, 1'b1};
    if (nxt > lim_x) begin
      nxt = lim_x;
    end
    if (!viol) begin
      step_cnt = '0;
    end else begin
      step_cnt = {(nxt == lim_x), nxt[CW-1:0]};
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SW-1:0]     oil_min_r, pressure_min_r, voltage_min_r, fuel_min_r;
  logic [CW-1:0]     oil_hold_r, pressure_hold_r, voltage_hold_r, fuel_hold_r;
  logic              cfg_wr;
  vap_pkg::cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = vap_pkg::cfg_reg_t'(paddr[vap_pkg::APB_ADDR_W-1:2]);

  // Write the selected register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oil_min_r       <= '0;
      pressure_min_r  <= '0;
      voltage_min_r   <= '0;
      fuel_min_r      <= '0;
      oil_hold_r      <= CW'(1);
      pressure_hold_r <= CW'(1);
      voltage_hold_r  <= CW'(1);
      fuel_hold_r     <= CW'(1);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        vap_pkg::REG_OIL_MIN:       oil_min_r       <= pwdata[SW-1:0];
        vap_pkg::REG_PRESSURE_MIN:  pressure_min_r  <= pwdata[SW-1:0];
        vap_pkg::REG_VOLTAGE_MIN:   voltage_min_r   <= pwdata[SW-1:0];
        vap_pkg::REG_FUEL_MIN:      fuel_min_r      <= pwdata[SW-1:0];
        vap_pkg::REG_OIL_HOLD:      oil_hold_r      <= pwdata[CW-1:0];
        vap_pkg::REG_PRESSURE_HOLD: pressure_hold_r <= pwdata[CW-1:0];
        vap_pkg::REG_VOLTAGE_HOLD:  voltage_hold_r  <= pwdata[CW-1:0];
        vap_pkg::REG_FUEL_HOLD:     fuel_hold_r     <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (cfg_sel)
      vap_pkg::REG_OIL_MIN:       prdata = DW'(oil_min_r);
      vap_pkg::REG_PRESSURE_MIN:  prdata = DW'(pressure_min_r);
      vap_pkg::REG_VOLTAGE_MIN:   prdata = DW'(voltage_min_r);
      vap_pkg::REG_FUEL_MIN:      prdata = DW'(fuel_min_r);
      vap_pkg::REG_OIL_HOLD:      prdata = DW'(oil_hold_r);
      vap_pkg::REG_PRESSURE_HOLD: prdata = DW'(pressure_hold_r);
      vap_pkg::REG_VOLTAGE_HOLD:  prdata = DW'(voltage_hold_r);
      vap_pkg::REG_FUEL_HOLD:     prdata = DW'(fuel_hold_r);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Clearing sweep after reset
  // ---------------------------------------------------------------------
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(ROWS - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: compare samples against thresholds, issue row read
  // ---------------------------------------------------------------------
  logic          in_acc;
  logic          in_range;
  logic [NC-1:0] viol_in;
  logic [AW-1:0] rd_addr;

  assign in_acc   = in_valid & in_ready;
  assign in_range = (32'(in_data.vehicle_index) < 32'(NUM_VEHICLES));
  assign rd_addr  = in_data.vehicle_index[AW-1:0];

  always_comb begin
    viol_in                    = '0;
    viol_in[vap_pkg::CH_OIL]   = in_data.oil_level < oil_min_r;
    viol_in[vap_pkg::CH_TRL]   = in_data.tire_rear_left < pressure_min_r;
    viol_in[vap_pkg::CH_TRR]   = in_data.tire_rear_right < pressure_min_r;
    viol_in[vap_pkg::CH_TFL]   = in_data.tire_front_left < pressure_min_r;
    viol_in[vap_pkg::CH_TFR]   = in_data.tire_front_right < pressure_min_r;
    viol_in[vap_pkg::CH_VOLT]  = in_data.battery_voltage < voltage_min_r;
    viol_in[vap_pkg::CH_FUEL]  = in_data.fuel_level < fuel_min_r;
    viol_in[vap_pkg::CH_BRAKE] = in_data.hard_braking;
    viol_in[vap_pkg::CH_DOOR]  = ~in_data.door_locked;
    viol_in[vap_pkg::CH_STEER] = in_data.hard_steering;
  end

  // ---------------------------------------------------------------------
  // Counter-row memory
  // ---------------------------------------------------------------------
  vap_pkg::row_t mem [ROWS];
  vap_pkg::row_t rd_row_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  vap_pkg::row_t mem_wdata;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Update stage: modify the row, write back, forward to the next sample
  // ---------------------------------------------------------------------
  logic                      s1_valid_r;
  logic                      s1_in_range_r;
  logic [NC-1:0]             s1_viol_r;
  logic [vap_pkg::VIDX_W-1:0] s1_vehicle_r;
  logic [AW-1:0]             s1_addr_r;
  logic                      s1_adv;

  logic                      wb_valid_r;
  logic [AW-1:0]             wb_addr_r;
  vap_pkg::row_t             wb_row_r;

  logic                      out_valid_r;
  vap_pkg::out_item_t        out_data_r;

  logic [CW-1:0]             lim [NC];
  vap_pkg::row_t             cur_row;
  vap_pkg::row_t             new_row;
  logic [NC-1:0]             flags;
  logic [CW:0]               upd;

  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~clr_active_r & (~s1_valid_r | s1_adv);

  // Hold limit of each channel
  always_comb begin
    lim[vap_pkg::CH_OIL]   = oil_hold_r;
    lim[vap_pkg::CH_TRL]   = pressure_hold_r;
    lim[vap_pkg::CH_TRR]   = pressure_hold_r;
    lim[vap_pkg::CH_TFL]   = pressure_hold_r;
    lim[vap_pkg::CH_TFR]   = pressure_hold_r;
    lim[vap_pkg::CH_VOLT]  = voltage_hold_r;
    lim[vap_pkg::CH_FUEL]  = fuel_hold_r;
    lim[vap_pkg::CH_BRAKE] = CW'(BRAKE_HOLD);
    lim[vap_pkg::CH_DOOR]  = CW'(DOOR_HOLD);
    lim[vap_pkg::CH_STEER] = CW'(STEER_HOLD);
  end

  // Take the last written row when it is the one being updated
  assign cur_row = (wb_valid_r && (wb_addr_r == s1_addr_r)) ? wb_row_r : rd_row_r;

  // Advance or clear every counter of the row
  always_comb begin
    new_row = '0;
    flags   = '0;
    upd     = '0;
    for (int k = 0; k < NC; k++) begin
      upd                  = step_cnt(cur_row[k*CW +: CW], s1_viol_r[k], lim[k]);
      new_row[k*CW +: CW]  = upd[CW-1:0];
      flags[k]             = upd[CW];
    end
  end

  // Memory write port: clearing sweep or row write-back
  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv & s1_in_range_r;
      mem_waddr = s1_addr_r;
      mem_wdata = new_row;
    end
  end

  // Update-stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_in_range_r) begin
        wb_valid_r <= 1'b1;
      end
    end
  end

  // Update-stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_in_range_r <= in_range;
      s1_viol_r     <= viol_in;
      s1_vehicle_r  <= in_data.vehicle_index;
      s1_addr_r     <= rd_addr;
    end
    if (s1_adv && s1_in_range_r) begin
      wb_addr_r <= s1_addr_r;
      wb_row_r  <= new_row;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.result_vehicle <= s1_vehicle_r;
      out_data_r.anomaly_flags  <= s1_in_range_r ? flags : '0;
      out_data_r.any_anomaly    <= s1_in_range_r & (|flags);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### verif/vehicle_anomaly_persistence_tb.sv
// Testbench for vehicle_anomaly_persistence: streams telemetry samples, predicts
// each flag word from a shadow counter store and checks every result transaction.
// Depends on vap_pkg and the vehicle_anomaly_persistence RTL.
`timescale 1ns / 1ps

module vehicle_anomaly_persistence_tb;

  localparam int NUM_VEH   = vap_pkg::DEF_NUM_VEHICLES;
  localparam int BRAKE_LIM = vap_pkg::DEF_BRAKE_HOLD;
  localparam int DOOR_LIM  = vap_pkg::DEF_DOOR_HOLD;
  localparam int STEER_LIM = vap_pkg::DEF_STEER_HOLD;
  localparam int NCH       = vap_pkg::NUM_CHANNELS;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  vap_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  vap_pkg::out_item_t             out_data;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [vap_pkg::APB_ADDR_W-1:0] paddr     = '0;
  logic [vap_pkg::APB_DATA_W-1:0] pwdata    = '0;
  logic [vap_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // Shadow of the threshold and hold registers
  logic [15:0] thr_oil, thr_tire, thr_volt, thr_fuel;
  logic [7:0]  lim_oil, lim_tire, lim_volt, lim_fuel;

  // Shadow persistence counters, one row per vehicle
  logic [7:0] run_count [NUM_VEH][NCH];

  vap_pkg::in_item_t  queued_samples [$];
  vap_pkg::out_item_t awaited_flags [$];
  int unsigned        error_count = 0;
  logic               in_taken = 1'b0;

  // Sender and receiver pacing state
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  vehicle_anomaly_persistence #(
    .NUM_VEHICLES(NUM_VEH),
    .BRAKE_HOLD  (BRAKE_LIM),
    .DOOR_HOLD   (DOOR_LIM),
    .STEER_HOLD  (STEER_LIM)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Append one sample to the pending list
  function automatic void queue_sample(vap_pkg::in_item_t s);
    queued_samples = {queued_samples, s};
  endfunction

  // Advance one saturating counter; flag when it sits at its limit
  function automatic bit count_run(int v, int ch, bit hit, int unsigned limit);
    int unsigned nxt;
    if (!hit) begin
      run_count[v][ch] = '0;
      return 1'b0;
    end
    nxt = run_count[v][ch] + 1;
    if (nxt > limit) nxt = limit;
    run_count[v][ch] = nxt[7:0];
    return nxt == limit;
  endfunction

  function automatic vap_pkg::out_item_t predict_result(vap_pkg::in_item_t s);
    vap_pkg::out_item_t r;
    int v;
    r = '0;
    v = s.vehicle_index;
    r.result_vehicle = s.vehicle_index;
    // Out-of-range vehicles leave the store alone and report no flags
    if (v < NUM_VEH) begin
      r.anomaly_flags[vap_pkg::CH_OIL] =
        count_run(v, vap_pkg::CH_OIL, s.oil_level < thr_oil, lim_oil);
      r.anomaly_flags[vap_pkg::CH_TRL] =
        count_run(v, vap_pkg::CH_TRL, s.tire_rear_left < thr_tire, lim_tire);
      r.anomaly_flags[vap_pkg::CH_TRR] =
        count_run(v, vap_pkg::CH_TRR, s.tire_rear_right < thr_tire, lim_tire);
      r.anomaly_flags[vap_pkg::CH_TFL] =
        count_run(v, vap_pkg::CH_TFL, s.tire_front_left < thr_tire, lim_tire);
      r.anomaly_flags[vap_pkg::CH_TFR] =
        count_run(v, vap_pkg::CH_TFR, s.tire_front_right < thr_tire, lim_tire);
      r.anomaly_flags[vap_pkg::CH_VOLT] =
        count_run(v, vap_pkg::CH_VOLT, s.battery_voltage < thr_volt, lim_volt);
      r.anomaly_flags[vap_pkg::CH_FUEL] =
        count_run(v, vap_pkg::CH_FUEL, s.fuel_level < thr_fuel, lim_fuel);
      r.anomaly_flags[vap_pkg::CH_BRAKE] =
        count_run(v, vap_pkg::CH_BRAKE, s.hard_braking, BRAKE_LIM);
      r.anomaly_flags[vap_pkg::CH_DOOR] =
        count_run(v, vap_pkg::CH_DOOR, !s.door_locked, DOOR_LIM);
      r.anomaly_flags[vap_pkg::CH_STEER] =
        count_run(v, vap_pkg::CH_STEER, s.hard_steering, STEER_LIM);
    end
    r.any_anomaly = |r.anomaly_flags;
    return r;
  endfunction

  // Pick a level on the requested side of a nonzero threshold, often right at the edge
  function automatic logic [15:0] pick_level(logic [15:0] floor_v, bit low);
    if (low && floor_v != 16'd0) begin
      if ($urandom_range(0, 3) == 0) return floor_v - 16'd1;
      return 16'($urandom_range(floor_v - 16'd1, 0));
    end
    if ($urandom_range(0, 3) == 0) return floor_v;
    return 16'($urandom_range(16'hFFFF, floor_v));
  endfunction

  // Build a sample whose conditions violate exactly where hit is set (nonzero thresholds)
  function automatic vap_pkg::in_item_t build_sample(int v, logic [NCH-1:0] hit);
    vap_pkg::in_item_t s;
    s.vehicle_index    = 8'(v);
    s.oil_level        = pick_level(thr_oil, hit[vap_pkg::CH_OIL]);
    s.tire_rear_left   = pick_level(thr_tire, hit[vap_pkg::CH_TRL]);
    s.tire_rear_right  = pick_level(thr_tire, hit[vap_pkg::CH_TRR]);
    s.tire_front_left  = pick_level(thr_tire, hit[vap_pkg::CH_TFL]);
    s.tire_front_right = pick_level(thr_tire, hit[vap_pkg::CH_TFR]);
    s.battery_voltage  = pick_level(thr_volt, hit[vap_pkg::CH_VOLT]);
    s.fuel_level       = pick_level(thr_fuel, hit[vap_pkg::CH_FUEL]);
    s.hard_braking     = hit[vap_pkg::CH_BRAKE];
    s.door_locked      = !hit[vap_pkg::CH_DOOR];
    s.hard_steering    = hit[vap_pkg::CH_STEER];
    return s;
  endfunction

  // Register write: setup cycle, then access cycle
  task automatic write_reg(vap_pkg::cfg_reg_t r, logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      vap_pkg::REG_OIL_MIN:       thr_oil  = value;
      vap_pkg::REG_PRESSURE_MIN:  thr_tire = value;
      vap_pkg::REG_VOLTAGE_MIN:   thr_volt = value;
      vap_pkg::REG_FUEL_MIN:      thr_fuel = value;
      vap_pkg::REG_OIL_HOLD:      lim_oil  = value[7:0];
      vap_pkg::REG_PRESSURE_HOLD: lim_tire = value[7:0];
      vap_pkg::REG_VOLTAGE_HOLD:  lim_volt = value[7:0];
      vap_pkg::REG_FUEL_HOLD:     lim_fuel = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [15:0] t_oil, logic [15:0] t_tire, logic [15:0] t_volt,
                              logic [15:0] t_fuel, logic [7:0] h_oil, logic [7:0] h_tire,
                              logic [7:0] h_volt, logic [7:0] h_fuel);
    write_reg(vap_pkg::REG_OIL_MIN, t_oil);
    write_reg(vap_pkg::REG_PRESSURE_MIN, t_tire);
    write_reg(vap_pkg::REG_VOLTAGE_MIN, t_volt);
    write_reg(vap_pkg::REG_FUEL_MIN, t_fuel);
    write_reg(vap_pkg::REG_OIL_HOLD, 16'(h_oil));
    write_reg(vap_pkg::REG_PRESSURE_HOLD, 16'(h_tire));
    write_reg(vap_pkg::REG_VOLTAGE_HOLD, 16'(h_volt));
    write_reg(vap_pkg::REG_FUEL_HOLD, 16'(h_fuel));
  endtask

  // Mostly runs of violations on a few hot vehicles, with some raw noise
  task automatic queue_traffic(int unsigned n_items, int unsigned max_run);
    int unsigned made, run_len, v, k;
    logic [NCH-1:0] base, hit;
    logic [127:0] raw;
    int unsigned hot [3];
    made = 0;
    foreach (hot[i]) hot[i] = $urandom_range(0, 255);
    while (made < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        queue_sample(raw[$bits(vap_pkg::in_item_t)-1:0]);
        made++;
      end else begin
        v = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 2)] : $urandom_range(0, 255);
        base = NCH'($urandom);
        if ($urandom_range(0, 3) == 0) base = '1;
        run_len = $urandom_range(1, max_run);
        for (k = 0; k < run_len; k++) begin
          hit = base;
          // break one condition's streak now and then
          if ($urandom_range(0, 7) == 0) hit[$urandom_range(0, NCH - 1)] = 1'b0;
          queue_sample(build_sample(v, hit));
          made++;
        end
      end
    end
  endtask

  // Hold until every queued sample is taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_samples.size() != 0 || in_valid || awaited_flags.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_samples.size() > 0) begin
        in_data  <= queued_samples.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            3:       gap_left = $urandom_range(4, 20);
            default: gap_left = $urandom_range(1, 3);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: rotate a stall pattern, reloading a new random one when its run ends
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'($urandom) | 16'h0001;
        2:       ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h8000;
        default: ready_pattern = 16'($urandom) | 16'($urandom);
      endcase
    end
    stall_left--;
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // Check each result transaction, then predict for each accepted sample
  always @(posedge clk) begin : check_results
    vap_pkg::out_item_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_flags.size() == 0) begin
          $error("unexpected result for vehicle %0d", out_data.result_vehicle);
          error_count++;
        end else begin
          want = awaited_flags.pop_front();
          if (out_data.result_vehicle !== want.result_vehicle) begin
            $error("result_vehicle: expected %0d, got %0d", want.result_vehicle,
                   out_data.result_vehicle);
            error_count++;
          end
          if (out_data.anomaly_flags !== want.anomaly_flags) begin
            $error("anomaly_flags: expected %b, got %b", want.anomaly_flags,
                   out_data.anomaly_flags);
            error_count++;
          end
          if (out_data.any_anomaly !== want.any_anomaly) begin
            $error("any_anomaly: expected %b, got %b", want.any_anomaly,
                   out_data.any_anomaly);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) awaited_flags = {awaited_flags, predict_result(in_data)};
    end
  end

  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    vap_pkg::in_item_t s;
    int unsigned long_veh, k;
    thr_oil  = '0;
    thr_tire = '0;
    thr_volt = '0;
    thr_fuel = '0;
    lim_oil  = 8'd1;
    lim_tire = 8'd1;
    lim_volt = 8'd1;
    lim_fuel = 8'd1;
    foreach (run_count[v, ch]) run_count[v][ch] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, saturation, clearing, threshold edges, interleaving
    apply_config(16'h4000, 16'h2000, 16'h0C00, 16'h1400, 8'd1, 8'd2, 8'd3, 8'd2);
    s = '0;
    queue_sample(s);
    s = '1;
    queue_sample(s);
    for (k = 0; k < 5; k++) queue_sample(build_sample(3, '1));
    queue_sample(build_sample(3, '0));
    s = '0;
    s.vehicle_index    = 8'd4;
    s.oil_level        = thr_oil;
    s.tire_rear_left   = thr_tire;
    s.tire_rear_right  = thr_tire;
    s.tire_front_left  = thr_tire;
    s.tire_front_right = thr_tire;
    s.battery_voltage  = thr_volt;
    s.fuel_level       = thr_fuel;
    s.door_locked      = 1'b1;
    queue_sample(s);
    s.oil_level        = thr_oil - 16'd1;
    s.tire_rear_left   = thr_tire - 16'd1;
    s.tire_rear_right  = thr_tire - 16'd1;
    s.tire_front_left  = thr_tire - 16'd1;
    s.tire_front_right = thr_tire - 16'd1;
    s.battery_voltage  = thr_volt - 16'd1;
    s.fuel_level       = thr_fuel - 16'd1;
    queue_sample(s);
    for (k = 0; k < 4; k++) begin
      queue_sample(build_sample(5, '1));
      queue_sample(build_sample(6, 10'h155));
    end
    wait_idle();

    // Small holds, moderate thresholds
    apply_config(16'h8000, 16'h6000, 16'h0D00, 16'h1000, 8'd1, 8'd2, 8'd3, 8'd4);
    queue_traffic(300, 8);
    wait_idle();

    // Top thresholds and top holds; drive one vehicle to the 255 ceiling
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
    long_veh = $urandom_range(0, 255);
    for (k = 0; k < 260; k++) queue_sample(build_sample(long_veh, '1));
    queue_traffic(100, 12);
    wait_idle();

    // Lower the holds under the saturated counts; tire hold of zero
    apply_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'd3, 8'd0, 8'd5, 8'd1);
    queue_sample(build_sample(long_veh, '1));
    queue_sample(build_sample(long_veh, '1));
    queue_traffic(300, 8);
    wait_idle();

    // Zero thresholds: only the event channels can fire
    apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1, 8'd1, 8'd1, 8'd1);
    queue_traffic(200, 6);
    wait_idle();

    // Random settings
    for (k = 0; k < 3; k++) begin
      apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                   8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)));
      queue_traffic(200, 14);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/vap_pkg.sv
rtl/vehicle_anomaly_persistence.sv
verif/vehicle_anomaly_persistence_tb.sv
